// File: rtl/msacl_pkg.sv
`default_nettype none
package msacl_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned DIV_W       = 16;
   localparam int unsigned DIV_CNT_W   = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PWM       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_PWM       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_PPM       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_CURRENT   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_CURRENT = 3'd4;

   localparam logic [7:0] MAX_PWM_RESET       = 8'd255;
   localparam logic [7:0] MIN_PWM_RESET       = 8'd10;
   localparam logic [7:0] MIN_PPM_RESET       = 8'd10;
   localparam logic [9:0] MAX_CURRENT_RESET   = 10'd255;
   localparam logic [7:0] LIMIT_CURRENT_RESET = 8'd65;

   localparam logic [7:0] PPM_FULL_SCALE    = 8'd200;
   localparam logic [9:0] PPM_INVALID_ABOVE = 10'd300;
   localparam logic [7:0] PPM_SPAN_TOP      = 8'd190;
   localparam int unsigned SLEW_SHIFT       = 5;
   localparam logic [7:0] PPM_FRAMES_NEEDED = 8'd20;

   // x / 200 == (x * SER_RECIP) >> SER_SHIFT for every 16-bit product of two bytes
   localparam logic [16:0] SER_RECIP = 17'd83887;
   localparam int unsigned SER_SHIFT = 24;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = 4'd15;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic load;
      logic start;
      logic step;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
   } dp_status_type;

endpackage
`default_nettype wire

// File: rtl/msacl_ctrl.sv
`default_nettype none
module msacl_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire msacl_pkg::dp_status_type status,
   output msacl_pkg::ctrl_cmd_type      cmd
);
   import msacl_pkg::*;

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.start = 1'b1;
            cnt_in    = '0;
            state_in  = status.need_div ? ST_DIV : ST_FIN;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// File: rtl/msacl_dp.sv
`default_nettype none
module msacl_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire msacl_pkg::ctrl_cmd_type             cmd,
   output msacl_pkg::dp_status_type                 status,
   input  wire logic                                csr_we,
   input  wire logic [msacl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [9:0]                          csr_data,
   input  wire logic                                req_i2c_valid,
   input  wire logic [7:0]                          req_i2c_setpoint,
   input  wire logic                                req_serial_valid,
   input  wire logic [7:0]                          req_serial_setpoint,
   input  wire logic [7:0]                          req_ppm_frames,
   input  wire logic [9:0]                          req_ppm_width,
   input  wire logic [9:0]                          req_current_sample,
   input  wire logic                                req_average_tick,
   output logic [7:0]                               rsp_duty,
   output logic [7:0]                               rsp_setpoint,
   output logic                                     rsp_ppm_mode,
   output logic                                     rsp_fault_led,
   output logic                                     rsp_cutoff,
   output logic [7:0]                               rsp_max_duty,
   output logic [7:0]                               rsp_mean_current
);
   import msacl_pkg::*;

   // configuration
   logic [7:0] max_pwm_ff, min_pwm_ff, min_ppm_ff, limit_current_ff;
   logic [9:0] max_current_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_pwm_ff       <= MAX_PWM_RESET;
         min_pwm_ff       <= MIN_PWM_RESET;
         min_ppm_ff       <= MIN_PPM_RESET;
         max_current_ff   <= MAX_CURRENT_RESET;
         limit_current_ff <= LIMIT_CURRENT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_PWM:       max_pwm_ff       <= csr_data[7:0];
            CSR_MIN_PWM:       min_pwm_ff       <= csr_data[7:0];
            CSR_MIN_PPM:       min_ppm_ff       <= csr_data[7:0];
            CSR_MAX_CURRENT:   max_current_ff   <= csr_data;
            CSR_LIMIT_CURRENT: limit_current_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // latched transaction
   logic       i2c_valid_ff, serial_valid_ff, tick_ff;
   logic [7:0] i2c_sp_ff, serial_sp_ff, frames_ff;
   logic [9:0] width_ff, cur_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         i2c_valid_ff    <= req_i2c_valid;
         i2c_sp_ff       <= req_i2c_setpoint;
         serial_valid_ff <= req_serial_valid;
         serial_sp_ff    <= req_serial_setpoint;
         frames_ff       <= req_ppm_frames;
         width_ff        <= req_ppm_width;
         cur_ff          <= req_current_sample;
         tick_ff         <= req_average_tick;
      end
   end

   // source select
   logic       src_ser, src_ppm, src_none;
   logic [7:0] w_eff, den, mul_a, mul_b, divisor;
   logic       ppm_zero, den_pos, ppm_neg;

   always_comb begin
      src_ser  = !i2c_valid_ff && serial_valid_ff;
      src_ppm  = !i2c_valid_ff && !serial_valid_ff && (frames_ff > PPM_FRAMES_NEEDED);
      src_none = !i2c_valid_ff && !serial_valid_ff && !src_ppm;
      if (width_ff > PPM_INVALID_ABOVE) begin
         w_eff = 8'd0;
      end else if (width_ff > {2'b00, PPM_FULL_SCALE}) begin
         w_eff = PPM_FULL_SCALE;
      end else begin
         w_eff = width_ff[7:0];
      end
      ppm_zero = (w_eff <= min_ppm_ff);
      den_pos  = (min_ppm_ff < PPM_SPAN_TOP);
      den      = PPM_SPAN_TOP - min_ppm_ff;
      ppm_neg  = (min_pwm_ff > max_pwm_ff);
      divisor  = den;
      if (src_ser) begin
         mul_a = max_pwm_ff;
         mul_b = serial_sp_ff;
      end else begin
         mul_a = ppm_neg ? (min_pwm_ff - max_pwm_ff) : (max_pwm_ff - min_pwm_ff);
         mul_b = w_eff - min_ppm_ff;
      end
      status.need_div = src_ppm && !ppm_zero && den_pos;
   end

   // restoring divider, one quotient bit per step
   logic [DIV_W-1:0] div_q_ff, div_q_in;
   logic [7:0]       div_r_ff, div_r_in, divisor_ff;
   logic [8:0]       rem_sh;

   always_comb begin
      rem_sh   = {div_r_ff, div_q_ff[DIV_W-1]};
      div_q_in = div_q_ff;
      div_r_in = div_r_ff;
      if (cmd.start) begin
         div_q_in = mul_a * mul_b;
         div_r_in = '0;
      end else if (cmd.step) begin
         if (rem_sh >= {1'b0, divisor_ff}) begin
            div_r_in = 8'(rem_sh - {1'b0, divisor_ff});
            div_q_in = {div_q_ff[DIV_W-2:0], 1'b1};
         end else begin
            div_r_in = rem_sh[7:0];
            div_q_in = {div_q_ff[DIV_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      div_q_ff <= div_q_in;
      div_r_ff <= div_r_in;
      if (cmd.start) begin
         divisor_ff <= divisor;
      end
   end

   // loop state
   logic [7:0] held_ff, held_in, dmax_ff, dmax_in, mean_ff, mean_in;
   logic       src_ff, src_in;
   logic [16:0] raw;
   logic [32:0] ser_scaled;
   logic [7:0]  sp, duty, dmax1;
   logic        over, led, mean_over;
   logic [9:0]  cur_eff;

   always_comb begin
      ser_scaled = {17'd0, div_q_ff} * SER_RECIP;
      if (i2c_valid_ff) begin
         raw = {9'd0, i2c_sp_ff};
      end else if (src_ser) begin
         raw = {8'd0, ser_scaled[32:SER_SHIFT]};
      end else if (src_ppm) begin
         if (ppm_zero) begin
            raw = '0;
         end else if (!den_pos) begin
            raw = {9'd0, max_pwm_ff};
         end else if (ppm_neg) begin
            raw = (div_q_ff > {8'd0, min_pwm_ff}) ? 17'd0
                  : {9'd0, 8'(min_pwm_ff - div_q_ff[7:0])};
         end else begin
            raw = {9'd0, min_pwm_ff} + {1'b0, div_q_ff};
         end
      end else begin
         raw = {9'd0, held_ff - {7'd0, (held_ff != 8'd0)}};
      end
      sp = (raw > {9'd0, max_pwm_ff}) ? max_pwm_ff : raw[7:0];

      src_in = src_ff;
      if (src_ppm) begin
         src_in = 1'b1;
      end else if (!src_none) begin
         src_in = 1'b0;
      end

      led  = src_none;
      duty = sp;
      if (sp > dmax_ff) begin
         duty = dmax_ff;
         led  = 1'b1;
      end
      over    = (cur_ff > max_current_ff);
      cur_eff = cur_ff;
      if (over) begin
         duty    = 8'd0;
         led     = 1'b1;
         cur_eff = cur_ff - 10'd1;
      end

      mean_in   = mean_ff;
      dmax1     = dmax_ff;
      dmax_in   = dmax_ff;
      mean_over = 1'b0;
      if (tick_ff) begin
         if ({2'b00, mean_ff} < cur_eff) begin
            mean_in = mean_ff + {7'd0, (mean_ff != 8'd255)};
         end else if ({2'b00, mean_ff} > cur_eff) begin
            mean_in = mean_ff - 8'd1;
         end
         if (cur_eff > max_current_ff) begin
            dmax1 = dmax_ff - (dmax_ff >> SLEW_SHIFT);
         end
         mean_over = (mean_in > limit_current_ff);
         if (mean_over) begin
            dmax_in = dmax1 - {7'd0, (dmax1 != 8'd0)};
            led     = 1'b1;
         end else if (dmax1 < max_pwm_ff) begin
            dmax_in = dmax1 + 8'd1;
         end else begin
            dmax_in = dmax1;
         end
      end
      held_in = sp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         dmax_ff <= MAX_PWM_RESET;
         mean_ff <= '0;
         src_ff  <= 1'b1;
      end else if (cmd.commit) begin
         held_ff <= held_in;
         dmax_ff <= dmax_in;
         mean_ff <= mean_in;
         src_ff  <= src_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_duty         <= duty;
         rsp_setpoint     <= sp;
         rsp_ppm_mode     <= src_in;
         rsp_fault_led    <= led;
         rsp_cutoff       <= over;
         rsp_max_duty     <= dmax_in;
         rsp_mean_current <= mean_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/motor_setpoint_and_current_limit.sv
// An accepted request goes through the MUL state, the DIV state when a PPM
// setpoint needs the 16-step restoring divider (serial scaling is a multiply),
// and FIN, which registers the response. A new request is taken only once the
// last is committed, and FIN holds while an earlier response waits for rsp_ready.
// Reset (synchronous, active high): registers to their defaults, held setpoint
// and mean current 0, duty maximum 255, PPM mode 1, no response pending.
`default_nettype none
module motor_setpoint_and_current_limit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [msacl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [9:0]                        csr_data,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_i2c_valid,
   input  wire logic [7:0]                        req_i2c_setpoint,
   input  wire logic                              req_serial_valid,
   input  wire logic [7:0]                        req_serial_setpoint,
   input  wire logic [7:0]                        req_ppm_frames,
   input  wire logic [9:0]                        req_ppm_width,
   input  wire logic [9:0]                        req_current_sample,
   input  wire logic                              req_average_tick,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [7:0]                             rsp_duty,
   output logic [7:0]                             rsp_setpoint,
   output logic                                   rsp_ppm_mode,
   output logic                                   rsp_fault_led,
   output logic                                   rsp_cutoff,
   output logic [7:0]                             rsp_max_duty,
   output logic [7:0]                             rsp_mean_current
);
   import msacl_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   msacl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   msacl_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_we              (csr_valid),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_i2c_valid       (req_i2c_valid),
      .req_i2c_setpoint    (req_i2c_setpoint),
      .req_serial_valid    (req_serial_valid),
      .req_serial_setpoint (req_serial_setpoint),
      .req_ppm_frames      (req_ppm_frames),
      .req_ppm_width       (req_ppm_width),
      .req_current_sample  (req_current_sample),
      .req_average_tick    (req_average_tick),
      .rsp_duty            (rsp_duty),
      .rsp_setpoint        (rsp_setpoint),
      .rsp_ppm_mode        (rsp_ppm_mode),
      .rsp_fault_led       (rsp_fault_led),
      .rsp_cutoff          (rsp_cutoff),
      .rsp_max_duty        (rsp_max_duty),
      .rsp_mean_current    (rsp_mean_current)
   );

endmodule
`default_nettype wire

// File: rtl/msacl_checker.sv
`default_nettype none
module msacl_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_duty,
   input wire logic [7:0] rsp_setpoint,
   input wire logic       rsp_fault_led,
   input wire logic       rsp_cutoff
);

   // a request is not accepted again in the cycle after one is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken on consecutive cycles");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_duty))
      else $error("stalled response changed");

   a_cutoff: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cutoff |-> rsp_duty == 8'd0 && rsp_fault_led)
      else $error("cutoff with drive or without fault");

   a_duty_le_sp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty <= rsp_setpoint)
      else $error("duty above setpoint");

   a_limit_led: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_duty != rsp_setpoint |-> rsp_fault_led)
      else $error("duty limited without fault");

endmodule

bind motor_setpoint_and_current_limit msacl_checker u_msacl_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_duty      (rsp_duty),
   .rsp_setpoint  (rsp_setpoint),
   .rsp_fault_led (rsp_fault_led),
   .rsp_cutoff    (rsp_cutoff)
);
`default_nettype wire

// File: tb/motor_setpoint_and_current_limit_tb.sv
`default_nettype none
module motor_setpoint_and_current_limit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import msacl_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;

   typedef struct packed {
      logic       i2c_valid;
      logic [7:0] i2c_setpoint;
      logic       serial_valid;
      logic [7:0] serial_setpoint;
      logic [7:0] ppm_frames;
      logic [9:0] ppm_width;
      logic [9:0] current_sample;
      logic       average_tick;
   } pass_in_t;

   typedef struct packed {
      logic [7:0] duty;
      logic [7:0] setpoint;
      logic       ppm_mode;
      logic       fault_led;
      logic       cutoff;
      logic [7:0] max_duty;
      logic [7:0] mean_current;
   } pass_out_t;

   class drive_result_tracker;
      logic [7:0] max_pwm, min_pwm, min_ppm, limit_current;
      logic [9:0] max_current;
      int         held_sp, duty_ceiling, mean_amps;
      logic       ppm_selected;
      pass_out_t  drive_results [$];
      int         mismatches;

      function new();
         max_pwm       = MAX_PWM_RESET;
         min_pwm       = MIN_PWM_RESET;
         min_ppm       = MIN_PPM_RESET;
         max_current   = MAX_CURRENT_RESET;
         limit_current = LIMIT_CURRENT_RESET;
         held_sp       = 0;
         duty_ceiling  = MAX_PWM_RESET;
         mean_amps     = 0;
         ppm_selected  = 1'b1;
         mismatches    = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [9:0] data);
         case (index)
            CSR_MAX_PWM:       max_pwm = data[7:0];
            CSR_MIN_PWM:       min_pwm = data[7:0];
            CSR_MIN_PPM:       min_ppm = data[7:0];
            CSR_MAX_CURRENT:   max_current = data;
            CSR_LIMIT_CURRENT: limit_current = data[7:0];
            default: ;
         endcase
      endfunction

      function void note_pass(pass_in_t p);
         int        top, bottom, lo, w, den, val, duty, cur, trip;
         logic      led, cut;
         pass_out_t exp_r;
         top    = max_pwm;
         bottom = min_pwm;
         lo     = min_ppm;
         trip   = max_current;
         led    = 1'b0;
         cut    = 1'b0;
         if (p.i2c_valid) begin
            held_sp = p.i2c_setpoint;
            ppm_selected = 1'b0;
         end else if (p.serial_valid) begin
            held_sp = (top * int'(p.serial_setpoint)) / int'(PPM_FULL_SCALE);
            ppm_selected = 1'b0;
         end else if (p.ppm_frames > PPM_FRAMES_NEEDED) begin
            ppm_selected = 1'b1;
            w = p.ppm_width;
            if (w > int'(PPM_INVALID_ABOVE)) w = 0;
            if (w > int'(PPM_FULL_SCALE)) w = PPM_FULL_SCALE;
            den = int'(PPM_SPAN_TOP) - lo;
            if (w <= lo) begin
               held_sp = 0;
            end else if (den <= 0) begin
               held_sp = top;
            end else begin
               val = bottom + ((top - bottom) * (w - lo)) / den;
               if (val < 0) val = 0;
               if (val > top) val = top;
               held_sp = val;
            end
         end else begin
            if (held_sp > 0) held_sp--;
            led = 1'b1;
         end
         if (held_sp > top) held_sp = top;

         duty = held_sp;
         if (duty > duty_ceiling) begin
            duty = duty_ceiling;
            led = 1'b1;
         end
         cur = p.current_sample;
         if (cur > trip) begin
            duty = 0;
            cut = 1'b1;
            led = 1'b1;
            cur--;
         end

         if (p.average_tick) begin
            if (mean_amps < cur) begin
               if (mean_amps < 255) mean_amps++;
            end else if (mean_amps > cur) begin
               mean_amps--;
            end
            if (cur > trip) duty_ceiling -= duty_ceiling >> SLEW_SHIFT;
            if (mean_amps > int'(limit_current)) begin
               if (duty_ceiling > 0) duty_ceiling--;
               led = 1'b1;
            end else if (duty_ceiling < top) begin
               duty_ceiling++;
            end
         end

         exp_r.duty         = 8'(duty);
         exp_r.setpoint     = 8'(held_sp);
         exp_r.ppm_mode     = ppm_selected;
         exp_r.fault_led    = led;
         exp_r.cutoff       = cut;
         exp_r.max_duty     = 8'(duty_ceiling);
         exp_r.mean_current = 8'(mean_amps);
         drive_results.push_back(exp_r);
      endfunction

      function void check_result(pass_out_t got);
         pass_out_t exp_r;
         if (drive_results.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: result transaction with nothing expected, duty %0d",
                        $time, got.duty);
            mismatches++;
            return;
         end
         exp_r = drive_results.pop_front();
         if (got.duty !== exp_r.duty || got.setpoint !== exp_r.setpoint ||
             got.ppm_mode !== exp_r.ppm_mode || got.fault_led !== exp_r.fault_led ||
             got.cutoff !== exp_r.cutoff || got.max_duty !== exp_r.max_duty ||
             got.mean_current !== exp_r.mean_current) begin
            if (mismatches < 10) begin
               $display("%0t: mismatch exp duty %0d sp %0d ppm %b led %b cut %b max %0d mean %0d",
                        $time, exp_r.duty, exp_r.setpoint, exp_r.ppm_mode, exp_r.fault_led,
                        exp_r.cutoff, exp_r.max_duty, exp_r.mean_current);
               $display("%0t:          got duty %0d sp %0d ppm %b led %b cut %b max %0d mean %0d",
                        $time, got.duty, got.setpoint, got.ppm_mode, got.fault_led,
                        got.cutoff, got.max_duty, got.mean_current);
            end
            mismatches++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [9:0]             csr_data;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_i2c_valid;
   logic [7:0]             req_i2c_setpoint;
   logic                   req_serial_valid;
   logic [7:0]             req_serial_setpoint;
   logic [7:0]             req_ppm_frames;
   logic [9:0]             req_ppm_width;
   logic [9:0]             req_current_sample;
   logic                   req_average_tick;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [7:0]             rsp_duty;
   logic [7:0]             rsp_setpoint;
   logic                   rsp_ppm_mode;
   logic                   rsp_fault_led;
   logic                   rsp_cutoff;
   logic [7:0]             rsp_max_duty;
   logic [7:0]             rsp_mean_current;

   drive_result_tracker    drive_tracker;
   int                     idle_cycles = 0;
   logic [CSR_INDEX_W-1:0] reg_order [5] = '{CSR_MAX_PWM, CSR_MIN_PWM, CSR_MIN_PPM,
                                             CSR_MAX_CURRENT, CSR_LIMIT_CURRENT};
   int                     fixed_cfg [5][5] = '{'{255, 0, 0, 1023, 255},
                                                '{1, 255, 189, 0, 0},
                                                '{200, 20, 50, 300, 100},
                                                '{128, 200, 190, 600, 30},
                                                '{255, 255, 255, 700, 40}};

   motor_setpoint_and_current_limit u_top (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) drive_tracker.write_reg(csr_index, csr_data);
         if (req_valid && req_ready)
            drive_tracker.note_pass(pass_in_t'{req_i2c_valid, req_i2c_setpoint,
                                               req_serial_valid, req_serial_setpoint,
                                               req_ppm_frames, req_ppm_width,
                                               req_current_sample, req_average_tick});
         if (rsp_valid && rsp_ready)
            drive_tracker.check_result(pass_out_t'{rsp_duty, rsp_setpoint, rsp_ppm_mode,
                                                   rsp_fault_led, rsp_cutoff, rsp_max_duty,
                                                   rsp_mean_current});
      end
      if ((csr_valid && csr_ready) || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : rsp_stall_pattern
      int style, span, period;
      rsp_ready = 1'b0;
      forever begin
         style  = $urandom_range(0, 2);
         span   = $urandom_range(10, 60);
         period = $urandom_range(2, 8);
         for (int k = 0; k < span; k++) begin
            @(negedge clock);
            case (style)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               default: rsp_ready <= (k % period == period - 1);
            endcase
         end
      end
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("** motor_setpoint_and_current_limit: FAILED **");
      $finish;
   end

   function automatic pass_in_t make_pass(bit i2c_v, int i2c_sp, bit ser_v, int ser_sp,
                                          int frames, int width, int cur, bit tick);
      pass_in_t p;
      p.i2c_valid       = i2c_v;
      p.i2c_setpoint    = 8'(i2c_sp);
      p.serial_valid    = ser_v;
      p.serial_setpoint = 8'(ser_sp);
      p.ppm_frames      = 8'(frames);
      p.ppm_width       = 10'(width);
      p.current_sample  = 10'(cur);
      p.average_tick    = tick;
      return p;
   endfunction

   task automatic send_pass(pass_in_t p);
      req_valid           <= 1'b1;
      req_i2c_valid       <= p.i2c_valid;
      req_i2c_setpoint    <= p.i2c_setpoint;
      req_serial_valid    <= p.serial_valid;
      req_serial_setpoint <= p.serial_setpoint;
      req_ppm_frames      <= p.ppm_frames;
      req_ppm_width       <= p.ppm_width;
      req_current_sample  <= p.current_sample;
      req_average_tick    <= p.average_tick;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic idle_sender(int n);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (drive_tracker.drive_results.size() != 0);
   endtask

   task automatic write_regs(input int v [5]);
      for (int k = 0; k < 5; k++) begin
         csr_valid <= 1'b1;
         csr_index <= reg_order[k];
         csr_data  <= 10'(v[k]);
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic run_random_passes(int count, int target);
      int       left, burst, gap, sel, mix, c;
      pass_in_t p;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 16);
         if (burst > left) burst = left;
         repeat (burst) begin
            sel = $urandom_range(0, 19);
            p.i2c_valid    = (sel < 5);
            p.serial_valid = (sel >= 5 && sel < 10) || (sel < 5 && $urandom_range(0, 1) == 1);
            p.i2c_setpoint = 8'($urandom);
            p.serial_setpoint = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 200))
                                                           : 8'($urandom);
            if (sel >= 17)
               p.ppm_frames = 8'($urandom_range(0, 20));
            else if (sel >= 10)
               p.ppm_frames = 8'($urandom_range(21, 255));
            else
               p.ppm_frames = 8'($urandom);
            p.ppm_width = ($urandom_range(0, 4) < 3) ? 10'($urandom_range(0, 210))
                                                     : 10'($urandom);
            mix = $urandom_range(0, 9);
            if (mix < 7) begin
               c = target + int'($urandom_range(0, 16)) - 8;
               if (c < 0) c = 0;
               if (c > 1023) c = 1023;
            end else if (mix < 9) begin
               c = $urandom_range(0, 1023);
            end else begin
               c = $urandom_range(0, target);
            end
            p.current_sample = 10'(c);
            p.average_tick   = ($urandom_range(0, 9) < 6);
            send_pass(p);
         end
         left -= burst;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) idle_sender(gap);
      end
   endtask

   initial begin
      pass_in_t directed [$];
      int       cfg [5];
      int       phase_target [8];
      drive_tracker       = new();
      reset               = 1'b1;
      csr_valid           = 1'b0;
      csr_index           = CSR_MAX_PWM;
      csr_data            = '0;
      req_valid           = 1'b0;
      req_i2c_valid       = 1'b0;
      req_i2c_setpoint    = '0;
      req_serial_valid    = 1'b0;
      req_serial_setpoint = '0;
      req_ppm_frames      = '0;
      req_ppm_width       = '0;
      req_current_sample  = '0;
      req_average_tick    = 1'b0;
      phase_target = '{120, 200, 30, 250, 60, 10, $urandom_range(0, 300),
                       $urandom_range(0, 300)};
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      directed.push_back(make_pass(0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_pass(1, 255, 1, 255, 255, 1023, 0, 1));
      directed.push_back(make_pass(1, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_pass(0, 0, 1, 200, 0, 0, 0, 0));
      directed.push_back(make_pass(0, 0, 1, 255, 0, 0, 0, 0));
      directed.push_back(make_pass(0, 0, 1, 0, 0, 0, 0, 0));
      directed.push_back(make_pass(0, 0, 0, 0, 21, 0, 0, 0));
      directed.push_back(make_pass(0, 0, 0, 0, 21, 10, 0, 0));
      directed.push_back(make_pass(0, 0, 0, 0, 21, 11, 0, 0));
      directed.push_back(make_pass(0, 0, 0, 0, 21, 190, 0, 0));
      directed.push_back(make_pass(0, 0, 0, 0, 21, 200, 0, 0));
      directed.push_back(make_pass(0, 0, 0, 0, 21, 201, 0, 0));
      directed.push_back(make_pass(0, 0, 0, 0, 21, 300, 0, 0));
      directed.push_back(make_pass(0, 0, 0, 0, 21, 301, 0, 0));
      directed.push_back(make_pass(0, 0, 0, 0, 255, 1023, 0, 0));
      directed.push_back(make_pass(1, 150, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_pass(0, 0, 0, 0, 20, 150, 0, 0));
      directed.push_back(make_pass(0, 0, 0, 0, 21, 100, 1023, 1));
      directed.push_back(make_pass(0, 0, 0, 0, 21, 100, 256, 1));
      directed.push_back(make_pass(0, 0, 0, 0, 21, 100, 255, 1));
      directed.push_back(make_pass(1, 255, 0, 0, 0, 0, 300, 1));
      directed.push_back(make_pass(0, 0, 0, 0, 0, 0, 0, 1));
      directed.push_back(make_pass(0, 0, 0, 0, 5, 0, 0, 1));
      directed.push_back(make_pass(1, 128, 0, 0, 0, 0, 0, 1));
      foreach (directed[k]) begin
         send_pass(directed[k]);
         if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 3));
      end

      for (int ph = 0; ph < 8; ph++) begin
         if (ph > 0) begin
            drain();
            if (ph < 6) begin
               cfg = fixed_cfg[ph - 1];
            end else begin
               cfg[0] = $urandom_range(1, 255);
               cfg[1] = $urandom_range(0, 255);
               cfg[2] = $urandom_range(0, 189);
               cfg[3] = $urandom_range(0, 1023);
               cfg[4] = $urandom_range(0, 255);
            end
            write_regs(cfg);
         end
         run_random_passes(170, phase_target[ph]);
      end

      drain();
      repeat (40) @(negedge clock);
      if (drive_tracker.mismatches == 0 && drive_tracker.drive_results.size() == 0)
         $display("** motor_setpoint_and_current_limit: PASSED **");
      else
         $display("** motor_setpoint_and_current_limit: FAILED **");
      $finish;
   end

endmodule
`default_nettype wire
